/* rtl/indexed_insert_remove_list_assert.svh */
// assertion macros for the indexed insert/remove list
// expects clk and arst_n in the scope of each use
`ifndef INDEXED_INSERT_REMOVE_LIST_ASSERT_SVH
`define INDEXED_INSERT_REMOVE_LIST_ASSERT_SVH

`ifndef SYNTHESIS

// property that holds at every clock edge outside reset
`define IIRL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define IIRL_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IIRL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define IIRL_ASSERT(lbl, prop, msg)
`define IIRL_ASSERT_IMPL(lbl, ante, cons, msg)
`define IIRL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/iirl_pkg.sv */
// shared types and constants of the indexed insert/remove list
// no dependencies
package iirl_pkg;

	// default configuration
	localparam int CAPACITY_DEF    = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	// operation codes
	typedef enum logic [1:0] {
		FUNC_READ   = 2'd0,
		FUNC_INSERT = 2'd1,
		FUNC_REMOVE = 2'd2,
		FUNC_FILL   = 2'd3
	} func_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} iirl_cmd_t;

endpackage

/* rtl/iirl_req_if.sv */
// request channel: valid/ready with operation payload
// no dependencies
interface iirl_req_if #(
	parameter int PW = 5,
	parameter int VW = 32
);
	logic          valid;
	logic          ready;
	logic [1:0]    func;
	logic [PW-1:0] position;
	logic [VW-1:0] value;

	modport source (output valid, func, position, value, input ready);
	modport sink   (input valid, func, position, value, output ready);
endinterface

/* rtl/iirl_rsp_if.sv */
// response channel: valid/ready with result payload
// no dependencies
interface iirl_rsp_if #(
	parameter int PW = 5,
	parameter int VW = 32
);
	logic          valid;
	logic          ready;
	logic [VW-1:0] element;
	logic [PW-1:0] count;
	logic [1:0]    status;

	modport source (output valid, element, count, status, input ready);
	modport sink   (input valid, element, count, status, output ready);
endinterface

/* rtl/iirl_ctrl.sv */
// controller: sequences accept, execute and response of one transaction
// depends on iirl_pkg and the assertion header
`include "indexed_insert_remove_list_assert.svh"

module iirl_ctrl import iirl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output iirl_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// handshake and datapath commands
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);
	assign cmd.load  = in_ready && in_valid;
	assign cmd.exec  = (state_q == S_EXEC);

	`IIRL_ASSERT(a_no_overlap, !(in_ready && out_valid), "accepting while a result is pending")
	`IIRL_ASSERT_NEXT(a_load_exec, cmd.load, cmd.exec, "accepted transaction not executed")
	`IIRL_ASSERT_NEXT(a_exec_valid, cmd.exec, out_valid, "executed transaction not presented")

endmodule

/* rtl/iirl_dpath.sv */
// datapath: element cells with parallel shift, length register, result registers
// depends on iirl_pkg and the assertion header
`include "indexed_insert_remove_list_assert.svh"

module iirl_dpath import iirl_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  iirl_cmd_t              cmd,
	input  logic [1:0]             in_func,
	input  logic [CNT_W-1:0]       in_position,
	input  logic [VALUE_WIDTH-1:0] in_value,
	output logic [VALUE_WIDTH-1:0] element,
	output logic [CNT_W-1:0]       count,
	output logic [1:0]             status
);

	localparam int IW = $clog2(CAPACITY);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	func_t                  func_q;
	logic [CNT_W-1:0]       pos_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [CNT_W-1:0]       used_q, used_d;
	logic [VALUE_WIDTH-1:0] cells_q [CAPACITY];
	logic [VALUE_WIDTH-1:0] element_q, elem_d;
	status_t                status_q, status_d;
	logic                   shift_up, shift_dn, do_fill;
	logic [VALUE_WIDTH-1:0] rd_word;

	// latch the accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func_t'(in_func);
			pos_q  <= in_position;
			val_q  <= in_value;
		end
	end

	// word at the requested position, valid only when position is below the length
	assign rd_word = cells_q[pos_q[IW-1:0]];

	// operation decode and range checks
	always_comb begin
		status_d = STAT_OK;
		elem_d   = '0;
		used_d   = used_q;
		shift_up = 1'b0;
		shift_dn = 1'b0;
		do_fill  = 1'b0;
		case (func_q)
			FUNC_READ: begin
				if (pos_q < used_q) elem_d = rd_word;
				else status_d = STAT_RANGE;
			end
			FUNC_INSERT: begin
				if (pos_q > used_q) begin
					status_d = STAT_RANGE;
				end else if (used_q == CAP_C) begin
					status_d = STAT_FULL;
				end else begin
					shift_up = 1'b1;
					used_d   = used_q + CNT_W'(1);
				end
			end
			FUNC_REMOVE: begin
				if (pos_q < used_q) begin
					elem_d   = rd_word;
					shift_dn = 1'b1;
					used_d   = used_q - CNT_W'(1);
				end else begin
					status_d = STAT_RANGE;
				end
			end
			FUNC_FILL: begin
				if (pos_q > CAP_C) begin
					status_d = STAT_RANGE;
				end else begin
					do_fill = 1'b1;
					used_d  = pos_q;
				end
			end
			default: begin
				status_d = STAT_RANGE;
			end
		endcase
	end

	// element cells, each compares its own index with the position
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		localparam int PREV = (g == 0) ? 0 : g - 1;
		localparam int NEXT = (g == CAPACITY - 1) ? g : g + 1;
		localparam logic [CNT_W-1:0] IDX = CNT_W'(g);

		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if (shift_up) begin
					if (IDX == pos_q) cells_q[g] <= val_q;
					else if (IDX > pos_q) cells_q[g] <= cells_q[PREV];
				end else if (shift_dn) begin
					if (IDX >= pos_q) cells_q[g] <= cells_q[NEXT];
				end else if (do_fill) begin
					if (IDX < pos_q) cells_q[g] <= val_q;
				end
			end
		end
	end

	// length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.exec) begin
			used_q <= used_d;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			element_q <= elem_d;
			status_q  <= status_d;
		end
	end

	assign element = element_q;
	assign count   = used_q;
	assign status  = status_q;

	`IIRL_ASSERT(a_used_cap, used_q <= CAP_C, "length beyond capacity")
	`IIRL_ASSERT_NEXT(a_err_hold, cmd.exec && (status_d != STAT_OK), $stable(used_q),
		"failed operation changed the length")
	`IIRL_ASSERT_IMPL(a_one_shift, cmd.exec, !(shift_up && shift_dn), "conflicting shift commands")

endmodule

/* rtl/indexed_insert_remove_list.sv */
// top level of the indexed insert/remove list
// depends on iirl_pkg, iirl_req_if, iirl_rsp_if, iirl_ctrl, iirl_dpath
//
// channel  dir  payload                     transaction
// req      in   func, position, value       valid && ready
// rsp      out  element, count, status      valid && ready
//
// each transaction passes through accept, execute in the cell array
// (all cells shift together), then present the result on rsp.
// req is not ready again until the result has been taken, so a stalled rsp
// holds off the next request.
// reset clears the length; cell contents stay undefined until written.
module indexed_insert_remove_list import iirl_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	iirl_req_if.sink  req,
	iirl_rsp_if.source rsp
);

	iirl_cmd_t cmd;

	// sequencing
	iirl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	// storage and operations
	iirl_dpath #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_func     (req.func),
		.in_position (req.position),
		.in_value    (req.value),
		.element     (rsp.element),
		.count       (rsp.count),
		.status      (rsp.status)
	);

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench for the indexed insert/remove list
// depends on iirl_pkg, iirl_req_if, iirl_rsp_if and indexed_insert_remove_list
// a queue-fed driver and a checking monitor compare every response with a list predictor
`timescale 1ns / 100ps

module tb_top;
	import iirl_pkg::*;

	localparam int CAP        = 16;
	localparam int PW         = 5;
	localparam int VW         = 32;
	localparam int N_RANDOM   = 1200;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN      = 8;

	typedef struct packed {
		logic [VW-1:0] element;
		logic [PW-1:0] count;
		status_t       status;
	} list_result_t;

	typedef struct {
		func_t         func;
		logic [PW-1:0] position;
		logic [VW-1:0] value;
		int unsigned   gap;
	} list_op_t;

	logic clk;
	logic arst_n;

	iirl_req_if #(.PW(PW), .VW(VW)) req_if ();
	iirl_rsp_if #(.PW(PW), .VW(VW)) rsp_if ();

	indexed_insert_remove_list #(
		.CAPACITY    (CAP),
		.VALUE_WIDTH (VW)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// shadow list kept by the predictor
	logic [VW-1:0] shadow_mem [CAP];
	int            shadow_len;

	list_op_t     pending_ops [$];
	list_result_t expected_results [$];

	int          n_req_acc;
	int          n_rsp_acc;
	int          n_driven;
	int          n_rsp_seen;
	int          error_count;
	int          idle_cycles;
	int unsigned gap_waited;
	int unsigned stall_left;
	bit          rsp_burst;
	int          func_seen [4];
	int          status_seen [3];
	list_op_t     drv_op;
	list_result_t exp_res;
	bit           any_accept;

	// predict the result of one operation and update the shadow list
	function automatic list_result_t predict_list_op(func_t f, logic [PW-1:0] pos,
			logic [VW-1:0] val);
		list_result_t r;
		int i;
		r.element = '0;
		r.status  = STAT_OK;
		case (f)
			FUNC_READ: begin
				if (pos < shadow_len)
					r.element = shadow_mem[pos];
				else
					r.status = STAT_RANGE;
			end
			FUNC_INSERT: begin
				// range check wins over the full check
				if (pos > shadow_len) begin
					r.status = STAT_RANGE;
				end else if (shadow_len >= CAP) begin
					r.status = STAT_FULL;
				end else begin
					for (i = shadow_len; i > pos; i--)
						shadow_mem[i] = shadow_mem[i-1];
					shadow_mem[pos] = val;
					shadow_len++;
				end
			end
			FUNC_REMOVE: begin
				if (pos < shadow_len) begin
					r.element = shadow_mem[pos];
					for (i = pos; i + 1 < shadow_len; i++)
						shadow_mem[i] = shadow_mem[i+1];
					shadow_len--;
				end else begin
					r.status = STAT_RANGE;
				end
			end
			default: begin
				if (pos > CAP) begin
					r.status = STAT_RANGE;
				end else begin
					for (i = 0; i < pos; i++)
						shadow_mem[i] = val;
					shadow_len = pos;
				end
			end
		endcase
		r.count = shadow_len[PW-1:0];
		return r;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// request driver: present queued transactions after their gap
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_if.valid || n_req_acc == n_driven) begin
				if (pending_ops.size() != 0 && gap_waited < pending_ops[0].gap) begin
					gap_waited++;
					req_if.valid <= 1'b0;
				end else if (pending_ops.size() != 0) begin
					drv_op = pending_ops.pop_front();
					req_if.valid    <= 1'b1;
					req_if.func     <= drv_op.func;
					req_if.position <= drv_op.position;
					req_if.value    <= drv_op.value;
					n_driven++;
					gap_waited = 0;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// response ready: stall a random number of cycles per transaction
	always @(negedge clk) begin
		if (arst_n) begin
			if (n_rsp_acc != n_rsp_seen) begin
				n_rsp_seen = n_rsp_acc;
				if ($urandom_range(0, 39) == 0)
					rsp_burst = !rsp_burst;
				stall_left = rsp_burst ? 0 : $urandom_range(0, 9);
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// monitor: check responses, predict accepted requests, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			any_accept = 1'b0;
			if (rsp_if.valid && rsp_if.ready) begin
				any_accept = 1'b1;
				n_rsp_acc++;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected response: element %h count %0d status %0d",
						$time, rsp_if.element, rsp_if.count, rsp_if.status);
					error_count++;
				end else begin
					exp_res = expected_results.pop_front();
					status_seen[exp_res.status]++;
					if (rsp_if.element !== exp_res.element) begin
						$display("%0t: element mismatch: expected %h, actual %h",
							$time, exp_res.element, rsp_if.element);
						error_count++;
					end
					if (rsp_if.count !== exp_res.count) begin
						$display("%0t: count mismatch: expected %0d, actual %0d",
							$time, exp_res.count, rsp_if.count);
						error_count++;
					end
					if (rsp_if.status !== exp_res.status) begin
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, exp_res.status, rsp_if.status);
						error_count++;
					end
				end
			end
			if (req_if.valid && req_if.ready) begin
				any_accept = 1'b1;
				n_req_acc++;
				func_seen[req_if.func]++;
				expected_results.push_back(predict_list_op(func_t'(req_if.func),
					req_if.position, req_if.value));
			end
			if (any_accept) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
					$display("Testbench completed WITH ERRORS");
					$finish;
				end
			end
		end
	end

	// add one transaction to the driver queue
	bit req_burst;

	task automatic queue_op(func_t f, int pos, logic [VW-1:0] val);
		list_op_t op;
		if ($urandom_range(0, 29) == 0)
			req_burst = !req_burst;
		op.func     = f;
		op.position = pos[PW-1:0];
		op.value    = val;
		op.gap      = req_burst ? 0 : $urandom_range(0, 9);
		pending_ops.push_back(op);
	endtask

	// stimulus, reset and end of run
	initial begin
		int gen_len;
		int k;
		int pos;
		int pick;
		func_t f;
		logic [VW-1:0] val;

		req_if.valid    = 1'b0;
		req_if.func     = '0;
		req_if.position = '0;
		req_if.value    = '0;
		rsp_if.ready    = 1'b0;
		arst_n          = 1'b0;
		shadow_len      = 0;
		n_req_acc       = 0;
		n_rsp_acc       = 0;
		n_driven        = 0;
		n_rsp_seen      = 0;
		error_count     = 0;
		idle_cycles     = 0;
		gap_waited      = 0;
		stall_left      = 0;
		rsp_burst       = 1'b0;
		req_burst       = 1'b0;
		foreach (func_seen[i])
			func_seen[i] = 0;
		foreach (status_seen[i])
			status_seen[i] = 0;

		// directed: empty list, shifting, full list, fill limits
		queue_op(FUNC_READ,   0,  32'h1111_1111);
		queue_op(FUNC_REMOVE, 0,  32'h2222_2222);
		queue_op(FUNC_INSERT, 1,  32'h3333_3333);
		queue_op(FUNC_INSERT, 0,  32'hFFFF_FFFF);
		queue_op(FUNC_INSERT, 1,  32'h0000_0000);
		queue_op(FUNC_INSERT, 0,  32'h1234_5678);
		queue_op(FUNC_READ,   2,  32'h0);
		queue_op(FUNC_READ,   31, 32'h0);
		queue_op(FUNC_REMOVE, 1,  32'h0);
		queue_op(FUNC_FILL,   0,  32'hDEAD_BEEF);
		queue_op(FUNC_READ,   0,  32'h0);
		queue_op(FUNC_FILL,   16, 32'hA5A5_A5A5);
		queue_op(FUNC_INSERT, 16, 32'h4444_4444);
		queue_op(FUNC_INSERT, 17, 32'h5555_5555);
		queue_op(FUNC_INSERT, 0,  32'h6666_6666);
		queue_op(FUNC_READ,   15, 32'h0);
		queue_op(FUNC_READ,   16, 32'h0);
		queue_op(FUNC_REMOVE, 15, 32'h0);
		queue_op(FUNC_INSERT, 15, 32'h5A5A_5A5A);
		queue_op(FUNC_REMOVE, 0,  32'h0);
		queue_op(FUNC_FILL,   17, 32'h7777_7777);
		queue_op(FUNC_FILL,   31, 32'hFFFF_FFFF);
		queue_op(FUNC_FILL,   1,  32'h0);
		queue_op(FUNC_REMOVE, 0,  32'h0);

		// random: mostly in-range positions, some raw positions
		gen_len = 0;
		for (k = 0; k < N_RANDOM; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				f = FUNC_READ;
			else if (pick < 62)
				f = FUNC_INSERT;
			else if (pick < 88)
				f = FUNC_REMOVE;
			else
				f = FUNC_FILL;
			if ($urandom_range(0, 99) < 15) begin
				pos = $urandom_range(0, 31);
			end else begin
				case (f)
					FUNC_INSERT: pos = $urandom_range(0, gen_len);
					FUNC_FILL:   pos = ($urandom_range(0, 3) == 0) ?
						$urandom_range(12, CAP) : $urandom_range(0, 6);
					default:     pos = (gen_len == 0) ? 0 : $urandom_range(0, gen_len - 1);
				endcase
			end
			case ($urandom_range(0, 15))
				0:       val = '0;
				1:       val = '1;
				default: val = $urandom;
			endcase
			queue_op(f, pos, val);
			// track the length to steer positions
			case (f)
				FUNC_INSERT: if (pos <= gen_len && gen_len < CAP) gen_len++;
				FUNC_REMOVE: if (pos < gen_len) gen_len--;
				FUNC_FILL:   if (pos <= CAP) gen_len = pos;
				default: ;
			endcase
		end

		// reset
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// drain
		while (pending_ops.size() != 0 || n_req_acc != n_driven)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("covered %0d transactions: %0d reads, %0d inserts, %0d removes, %0d fills",
			n_rsp_acc, func_seen[FUNC_READ], func_seen[FUNC_INSERT],
			func_seen[FUNC_REMOVE], func_seen[FUNC_FILL]);
		$display("responses with status ok %0d, out of range %0d, list full %0d",
			status_seen[STAT_OK], status_seen[STAT_RANGE], status_seen[STAT_FULL]);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
